### hdl/lottery_scheduler_assert.svh
// assertion macros for the lottery scheduler checks
`ifndef LOTTERY_SCHEDULER_ASSERT_SVH
`define LOTTERY_SCHEDULER_ASSERT_SVH

// checked outside reset
`define LSCH_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lottery_scheduler check failed");

// checked in and out of reset
`define LSCH_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("lottery_scheduler reset check failed");

`endif

### hdl/lsch_pkg.sv
package lsch_pkg;

   localparam int RAND_W         = 16;
   localparam int DIV_STEP_W     = 4;
   localparam int TICKET_W       = 8;
   localparam int TICKET_TABLE_W = 64;
   localparam int TASK_W         = 4;
   localparam int WINNER_W       = 3;
   localparam int WINS_W         = 32;
   localparam int RSP_DATA_W     = 40;
   localparam int CSR_INDEX_W    = 8;
   localparam int CSR_DATA_W     = 64;

   localparam int DEF_MAX_SLOTS  = 8;
   localparam int DEF_COUNT_BITS = 32;

   localparam logic [TICKET_TABLE_W-1:0] TICKET_RESET = 64'h0101_0101_0101_0101;
   localparam logic [TASK_W-1:0]         TASK_RESET   = 4'd8;

   localparam logic [CSR_INDEX_W-1:0] CSR_TICKETS = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TASKS   = 8'd1;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

endpackage

### hdl/lottery_scheduler.sv
// channel   dir  handshake                 payload
// req       in   req_tvalid/req_tready     req_tdata: random_value
// rsp       out  rsp_tvalid/rsp_tready     rsp_tdata: winner, winner_wins; rsp_tuser: empty_pool
// csr       in   csr_valid/csr_ready       csr_index, csr_data
//
// one draw adds up the pool over the n active tasks, finds the remainder by restoring
// division and walks the slots, all on one shared adder, then posts the beat;
// an empty pool skips the division and the walk
// synchronous active-high reset clears win counters and handshake state and loads the default config
// a new draw is taken while the last result beat still waits on rsp_tready
// csr writes are always ready and are meant for idle periods
module lottery_scheduler
   import lsch_pkg::*;
#(
   parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [RAND_W-1:0]      req_tdata,   // random_value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // winner, winner_wins, zero pad
   output logic                   rsp_tuser,   // empty_pool
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int TOT_W = TICKET_W + $clog2(MAX_SLOTS) + 1;
   localparam int ALU_W = TOT_W + 1;
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SUM  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_WALK = 5'b01000,
      ST_UPD  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [TICKET_TABLE_W-1:0] tickets_ff;
   logic [TASK_W-1:0]       tasks_ff;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [TOT_W-1:0]        total_ff, total_in;
   logic [TOT_W-1:0]        rem_ff, rem_in;
   logic [RAND_W-1:0]       rv_ff, rv_in;
   logic [DIV_STEP_W-1:0]   step_ff, step_in;
   logic [IDX_W-1:0]        win_ff, win_in;
   logic                    empty_ff, empty_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WINNER_W-1:0]     rsp_winner_ff, rsp_winner_in;
   logic [WINS_W-1:0]       rsp_wins_ff, rsp_wins_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   logic [TICKET_W-1:0]     tick_w [MAX_SLOTS];
   logic [CNT_W-1:0]        active_n;
   logic [IDX_W-1:0]        k_idx;
   logic [TICKET_W-1:0]     cur_tick;
   logic [ALU_W-1:0]        div_shift;
   alu_op_type              alu_op;
   logic [ALU_W-1:0]        alu_a, alu_b, alu_res;
   logic                    alu_borrow;
   logic                    req_beat, post;
   logic [COUNT_BITS-1:0]   new_count;

   for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_tick
      assign tick_w[g] = tickets_ff[TICKET_W*g +: TICKET_W];
   end

   always_comb begin
      if (tasks_ff > TASK_W'(MAX_SLOTS)) begin
         active_n = CNT_W'(MAX_SLOTS);
      end else begin
         active_n = CNT_W'(tasks_ff);
      end
   end

   assign k_idx     = (k_ff < CNT_W'(MAX_SLOTS)) ? k_ff[IDX_W-1:0] : '0;
   assign cur_tick  = tick_w[k_idx];
   assign div_shift = {rem_ff, rv_ff[RAND_W-1]};

   always_comb begin
      case (state_ff)
         ST_DIV: begin
            alu_op = ALU_SUB;
            alu_a  = div_shift;
            alu_b  = ALU_W'(total_ff);
         end
         ST_WALK: begin
            alu_op = ALU_SUB;
            alu_a  = ALU_W'(rem_ff);
            alu_b  = ALU_W'(cur_tick);
         end
         default: begin
            alu_op = ALU_ADD;
            alu_a  = ALU_W'(total_ff);
            alu_b  = ALU_W'(cur_tick);
         end
      endcase
   end

   lsch_alu #(
      .W(ALU_W)
   ) u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_res),
      .borrow (alu_borrow)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid & req_tready;
   assign post       = (state_ff == ST_UPD) & (~rsp_valid_ff | rsp_tready);

   lsch_counters #(
      .MAX_SLOTS  (MAX_SLOTS),
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W)
   ) u_counters (
      .clock     (clock),
      .reset     (reset),
      .inc       (post & ~empty_ff),
      .idx       (win_ff),
      .new_count (new_count)
   );

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      total_in = total_ff;
      rem_in   = rem_ff;
      rv_in    = rv_ff;
      step_in  = step_ff;
      win_in   = win_ff;
      empty_in = empty_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               rv_in    = req_tdata;
               k_in     = '0;
               total_in = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (k_ff < active_n) begin
               total_in = alu_res[TOT_W-1:0];
               k_in     = k_ff + CNT_W'(1);
            end else if (total_ff == '0) begin
               empty_in = 1'b1;
               win_in   = '0;
               state_in = ST_UPD;
            end else begin
               empty_in = 1'b0;
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = alu_borrow ? div_shift[TOT_W-1:0] : alu_res[TOT_W-1:0];
            rv_in   = {rv_ff[RAND_W-2:0], 1'b0};
            step_in = step_ff + DIV_STEP_W'(1);
            if (step_ff == DIV_STEP_W'(RAND_W - 1)) begin
               k_in     = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (alu_borrow || (k_ff == active_n - CNT_W'(1))) begin
               win_in   = k_idx;
               state_in = ST_UPD;
            end else begin
               rem_in = alu_res[TOT_W-1:0];
               k_in   = k_ff + CNT_W'(1);
            end
         end
         ST_UPD: begin
            if (post) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_winner_in = rsp_winner_ff;
      rsp_wins_in   = rsp_wins_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (post) begin
         rsp_valid_in  = 1'b1;
         rsp_empty_in  = empty_ff;
         rsp_winner_in = empty_ff ? '0 : WINNER_W'(win_ff);
         rsp_wins_in   = empty_ff ? '0 : WINS_W'(new_count);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tickets_ff   <= TICKET_RESET;
         tasks_ff     <= TASK_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TICKETS) begin
               tickets_ff <= csr_data;
            end else if (csr_index == CSR_TASKS) begin
               tasks_ff <= csr_data[TASK_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      total_ff      <= total_in;
      rem_ff        <= rem_in;
      rv_ff         <= rv_in;
      step_ff       <= step_in;
      win_ff        <= win_in;
      empty_ff      <= empty_in;
      rsp_winner_ff <= rsp_winner_in;
      rsp_wins_ff   <= rsp_wins_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_empty_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - WINS_W - WINNER_W){1'b0}}, rsp_wins_ff, rsp_winner_ff};

endmodule

### hdl/lsch_alu.sv
module lsch_alu
   import lsch_pkg::*;
#(
   parameter int W = 12
) (
   input  alu_op_type     op,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   output logic [W-1:0]   result,
   output logic           borrow
);

   logic [W-1:0] b_eff;
   logic [W:0]   full;

   // one adder: subtract is a plus inverted b plus one
   assign b_eff  = (op == ALU_SUB) ? ~b : b;
   assign full   = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, (op == ALU_SUB)};
   assign result = full[W-1:0];
   assign borrow = (op == ALU_SUB) & ~full[W];

endmodule

### hdl/lsch_counters.sv
module lsch_counters #(
   parameter int MAX_SLOTS  = 8,
   parameter int COUNT_BITS = 32,
   parameter int IDX_W      = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  inc,
   input  logic [IDX_W-1:0]      idx,
   output logic [COUNT_BITS-1:0] new_count
);

   logic [COUNT_BITS-1:0] count_ff [MAX_SLOTS];
   logic [COUNT_BITS-1:0] cur;

   assign cur       = count_ff[idx];
   // saturating bump
   assign new_count = (cur == {COUNT_BITS{1'b1}}) ? cur : cur + {{(COUNT_BITS-1){1'b0}}, 1'b1};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (inc) begin
         count_ff[idx] <= new_count;
      end
   end

endmodule

### hdl/lsch_checker.sv
`include "lottery_scheduler_assert.svh"

module lsch_checker
   import lsch_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata,
   input logic                   rsp_tuser
);

   // a stalled result beat stays up
   `LSCH_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid)

   // an empty pool beat carries no winner and no count
   `LSCH_ASSERT(a_empty_zero, rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)

   // a draw keeps the block busy for at least the next cycle
   `LSCH_ASSERT(a_busy_after_req, req_tvalid && req_tready |=> !req_tready)

   // reset drops any pending result beat
   `LSCH_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> !rsp_tvalid)

endmodule

bind lottery_scheduler lsch_checker u_lsch_checker (.*);

### tb/tb_lottery_scheduler.sv
module tb_lottery_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   import lsch_pkg::*;

   typedef struct packed {
      logic [WINNER_W-1:0] winner;
      logic [WINS_W-1:0]   wins;
      logic                empty_pool;
   } draw_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RAND_W-1:0]      req_tdata;   // random_value
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;   // winner, winner_wins, zero pad
   logic                   rsp_tuser;   // empty_pool
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // scheduler shadow state
   logic [TICKET_TABLE_W-1:0] ticket_bytes;
   logic [TASK_W-1:0]         task_total;
   logic [DEF_COUNT_BITS-1:0] win_tally [DEF_MAX_SLOTS];

   draw_result_type expected_draws[$];
   int              mismatch_count;
   bit              no_idle;

   lottery_scheduler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic draw_result_type pick_winner(input logic [RAND_W-1:0] rv);
      draw_result_type r;
      int              active;
      int              pool;
      int              draw_pt;
      int              running;
      int              idx;
      bit              found;
      r = '0;
      active = (task_total > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : int'(task_total);
      pool = 0;
      for (int k = 0; k < active; k++) pool += ticket_bytes[8*k +: 8];
      if (pool == 0) begin
         r.empty_pool = 1'b1;
         return r;
      end
      draw_pt = int'(rv) % pool;
      running = 0;
      idx = 0;
      found = 1'b0;
      for (int k = 0; k < active; k++) begin
         if (!found) begin
            running += ticket_bytes[8*k +: 8];
            if (draw_pt < running) begin
               idx = k;
               found = 1'b1;
            end
         end
      end
      if (win_tally[idx] != '1) win_tally[idx] = win_tally[idx] + 1'b1;
      r.winner = WINNER_W'(idx);
      r.wins = win_tally[idx][WINS_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_beats
      draw_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_draws.size() == 0) begin
            report_mismatch("beat with no draw pending", rsp_tdata, 0);
         end else begin
            want = expected_draws.pop_front();
            if (rsp_tdata[WINNER_W-1:0] !== want.winner)
               report_mismatch("winner", rsp_tdata[WINNER_W-1:0], want.winner);
            if (rsp_tdata[WINNER_W +: WINS_W] !== want.wins)
               report_mismatch("winner_wins", rsp_tdata[WINNER_W +: WINS_W], want.wins);
            if (rsp_tuser !== want.empty_pool)
               report_mismatch("empty_pool", rsp_tuser, want.empty_pool);
         end
      end
   end

   // result side back-pressure
   initial begin : rsp_stall
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic send_draw(input logic [RAND_W-1:0] rv);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = rv;
      do @(posedge clock); while (!req_tready);
      expected_draws.push_back(pick_winner(rv));
      @(negedge clock);
   endtask

   task automatic wait_idle;
      req_tvalid = 1'b0;
      while (expected_draws.size() > 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_TICKETS) ticket_bytes = data;
      else if (idx == CSR_TASKS) task_total = data[TASK_W-1:0];
      @(negedge clock);
   endtask

   task automatic set_config(input logic [TICKET_TABLE_W-1:0] tickets,
                             input logic [TASK_W-1:0] tasks);
      wait_idle();
      write_csr(CSR_TICKETS, tickets);
      write_csr(CSR_TASKS, {{(CSR_DATA_W-TASK_W){1'b0}}, tasks});
      csr_valid = 1'b0;
   endtask

   task automatic test_reset_defaults;
      send_draw(16'h0000);
      send_draw(16'hFFFF);
      send_draw(16'd7);
      send_draw(16'd8);
   endtask

   task automatic test_pool_extremes;
      set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
      send_draw(16'h0000);
      send_draw(16'hFFFF);
      send_draw(16'd2039);
      send_draw(16'd255);
   endtask

   task automatic test_empty_pool;
      set_config(64'h0, 4'd8);
      send_draw(16'h1234);
      send_draw(16'hFFFF);
      // no active tasks
      set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
      send_draw(16'd5);
      // tickets only outside the active range
      set_config(64'hFF00_0000_0000_0000, 4'd4);
      send_draw(16'hABCD);
   endtask

   task automatic test_task_count_range;
      set_config(64'h0807_0605_0403_0201, 4'd15);
      send_draw(16'd35);
      send_draw(16'hFFFF);
      set_config(64'h0807_0605_0403_0201, 4'd9);
      send_draw(16'd20);
      set_config(64'hFFFF_FFFF_FFFF_FF01, 4'd1);
      send_draw(16'hFFFF);
   endtask

   task automatic test_zero_ticket_tasks;
      set_config(64'h0000_0000_0003_0001, 4'd8);
      for (int v = 0; v < 5; v++) send_draw(v[RAND_W-1:0]);
      set_config(64'hFF00_0000_0000_0000, 4'd8);
      send_draw(16'h0000);
      send_draw(16'hFFFF);
   endtask

   task automatic test_random_draws;
      logic [TICKET_TABLE_W-1:0] tickets_val;
      logic [TASK_W-1:0]         tasks_val;
      logic [RAND_W-1:0]         rv;
      int                        sel;
      for (int p = 0; p < 13; p++) begin
         for (int b = 0; b < 8; b++) begin
            sel = $urandom_range(0, 5);
            case (sel)
               0: tickets_val[8*b +: 8] = 8'h00;
               1: tickets_val[8*b +: 8] = 8'hFF;
               2: tickets_val[8*b +: 8] = 8'($urandom_range(1, 3));
               default: tickets_val[8*b +: 8] = 8'($urandom_range(0, 255));
            endcase
         end
         if ($urandom_range(0, 11) == 0) tickets_val = '0;
         tasks_val = TASK_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(1, 8));
         no_idle = ($urandom_range(0, 3) == 0);
         set_config(tickets_val, tasks_val);
         repeat (150) begin
            sel = $urandom_range(0, 9);
            case (sel)
               0: rv = 16'hFFFF;
               1: rv = RAND_W'($urandom_range(0, 15));
               default: rv = RAND_W'($urandom_range(0, 65535));
            endcase
            send_draw(rv);
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      no_idle = 1'b0;
      mismatch_count = 0;
      ticket_bytes = TICKET_RESET;
      task_total = TASK_RESET;
      for (int k = 0; k < DEF_MAX_SLOTS; k++) win_tally[k] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_pool_extremes();
      test_empty_pool();
      test_task_count_range();
      test_zero_ticket_tasks();
      test_random_draws();

      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && expected_draws.size() == 0) begin
         $display("[lottery_scheduler] OK");
      end else begin
         $display("[lottery_scheduler] ERROR");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("[lottery_scheduler] ERROR");
      $finish;
   end

endmodule
